>>> hw/rtl/scar_pkg.sv
// shared types, constants and index helpers for the chunk acknowledge receiver
`timescale 1ns / 1ps
`default_nettype none

package scar_pkg;

  localparam int CHUNK_BYTES  = 1024;
  localparam int INDEX_LIMIT  = 128;
  localparam int HEADER_BYTES = 4;

  localparam int IDX_W  = 8;
  localparam int CNT_W  = 7;
  localparam int SUM_W  = 14;
  localparam int DLEN_W = 16;
  localparam int DECL_W = 32;

  localparam int REM_DEPTH = 256;

  typedef logic signed [IDX_W-1:0]  idx_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [SUM_W-1:0]  sum_t;
  typedef logic        [DLEN_W-1:0] dlen_t;
  typedef logic signed [DECL_W-1:0] decl_t;

  localparam cnt_t COUNT_MAX = '1;

  typedef struct packed {
    idx_t  chunk_index;
    logic  first_chunk;
    logic  last_chunk;
    dlen_t datagram_length;
    decl_t declared_length;
  } chunk_item_t;

  typedef struct packed {
    idx_t prev;
    cnt_t count;
    sum_t counted_sum;
    sum_t all_sum;
    logic broken;
  } run_state_t;

  localparam run_state_t RUN_CLEAR = '{
    prev:        idx_t'(-1),
    count:       '0,
    counted_sum: '0,
    all_sum:     '0,
    broken:      1'b0
  };

  typedef logic [IDX_W-1:0] rem_table_t [REM_DEPTH];

  // magnitude mod INDEX_LIMIT, built by counting so no divider is involved
  function automatic rem_table_t build_rem_table();
    rem_table_t tbl;
    int         r;
    r = 0;
    for (int i = 0; i < REM_DEPTH; i++) begin
      tbl[i] = IDX_W'(r);
      r = (r + 1 == INDEX_LIMIT) ? 0 : r + 1;
    end
    return tbl;
  endfunction

  localparam rem_table_t REM_TABLE = build_rem_table();

  // expected next index: truncated remainder of prev + 1
  function automatic idx_t next_index(input idx_t prev);
    logic signed [IDX_W:0] x;
    logic        [IDX_W-1:0] mag;
    logic        [IDX_W-1:0] r;
    x   = (IDX_W+1)'(prev) + (IDX_W+1)'(1);
    mag = x[IDX_W] ? IDX_W'(-x) : x[IDX_W-1:0];
    r   = REM_TABLE[mag];
    return x[IDX_W] ? idx_t'(-r) : idx_t'(r);
  endfunction

  // prev - 1 brought into 0 .. INDEX_LIMIT-1
  function automatic idx_t step_back(input idx_t prev);
    logic signed [IDX_W:0] x;
    logic        [IDX_W-1:0] mag;
    logic        [IDX_W-1:0] r;
    x   = (IDX_W+1)'(prev) - (IDX_W+1)'(1);
    mag = x[IDX_W] ? IDX_W'(-x) : x[IDX_W-1:0];
    r   = REM_TABLE[mag];
    if (!x[IDX_W] || r == '0) begin
      return idx_t'(r);
    end
    return idx_t'(IDX_W'(INDEX_LIMIT) - r);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scar_ifs.sv
// valid/ready channel interfaces for chunk headers and acknowledge results
`timescale 1ns / 1ps
`default_nettype none

interface scar_chunk_if;
  import scar_pkg::*;

  logic  valid;
  logic  ready;
  idx_t  chunk_index;
  logic  first_chunk;
  logic  last_chunk;
  dlen_t datagram_length;
  decl_t declared_length;

  modport source (
    output valid, chunk_index, first_chunk, last_chunk, datagram_length, declared_length,
    input  ready
  );
  modport sink (
    input  valid, chunk_index, first_chunk, last_chunk, datagram_length, declared_length,
    output ready
  );
endinterface

interface scar_ack_if;
  import scar_pkg::*;

  logic  valid;
  logic  ready;
  logic  finished;
  idx_t  ack_index;
  cnt_t  whole_chunks;
  decl_t final_chunk_bytes;
  logic  truncated;

  modport source (
    output valid, finished, ack_index, whole_chunks, final_chunk_bytes, truncated,
    input  ready
  );
  modport sink (
    input  valid, finished, ack_index, whole_chunks, final_chunk_bytes, truncated,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/scar_seq_track.sv
// running sequence tracker: in-sequence count, index sums and break flag
`timescale 1ns / 1ps
`default_nettype none

module scar_seq_track (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       advance,
  input  wire scar_pkg::chunk_item_t item,
  output scar_pkg::run_state_t      run_next
);
  import scar_pkg::*;

  run_state_t run;
  run_state_t base;
  idx_t       want;
  logic       count_it;
  sum_t       idx_ext;

  always_comb begin
    base     = item.first_chunk ? RUN_CLEAR : run;
    run_next = base;
    want     = next_index(base.prev);
    count_it = 1'b0;
    idx_ext  = SUM_W'(item.chunk_index);
    if (!base.broken) begin
      if (base.count == '0) begin
        run_next.prev = item.chunk_index;
        count_it      = 1'b1;
      end else if (item.chunk_index == want) begin
        run_next.prev = want;
        count_it      = 1'b1;
      end else begin
        run_next.broken = 1'b1;
      end
    end
    if (count_it) begin
      if (base.count != COUNT_MAX) begin
        run_next.count = base.count + cnt_t'(1);
      end
      run_next.counted_sum = base.counted_sum + idx_ext;
    end
    run_next.all_sum = base.all_sum + idx_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= RUN_CLEAR;
    end else if (advance) begin
      run <= run_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sequenced_chunk_ack_receiver.sv
// top level: chunk header receiver producing one acknowledge word per datagram
// chunk_in carries one chunk header word per handshake (valid/ready); the
// chunk marked last of each datagram produces one word on ack_out, other
// chunks produce none.
// a header is captured in an input register; from there the sequence
// tracker updates the running count and index sums and the result is
// computed and loaded into the output register.
// two register stages (input register, output register). throughput: one
// header per cycle while ack_out does not stall a waiting last chunk.
// the output register lets the input stage keep taking headers without a
// result while an acknowledge word waits; when ack_out stalls and a last
// chunk is waiting in the input register, chunk_in.ready drops until the
// output word is taken.
// reset (synchronous, rst high) empties both stages and clears the running
// state to "no index seen"; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sequenced_chunk_ack_receiver (
  input wire        clk,
  input wire        rst,
  scar_chunk_if.sink  chunk_in,
  scar_ack_if.source  ack_out
);
  import scar_pkg::*;

  localparam logic signed [17:0] CHUNK_BYTES_S = 18'(CHUNK_BYTES);

  chunk_item_t s1_item;
  logic        s1_valid;
  logic        s1_move;
  logic        out_free;
  run_state_t  run_next;

  logic                     res_finished;
  idx_t                     res_ack;
  cnt_t                     res_whole;
  decl_t                    res_bytes;
  logic                     res_trunc;
  logic signed [DECL_W:0]   payload_len;
  logic signed [IDX_W:0]    cnt_m1;
  logic signed [IDX_W:0]    whole_s;
  logic signed [26:0]       span;

  logic  out_valid;
  logic  out_finished;
  idx_t  out_ack;
  cnt_t  out_whole;
  decl_t out_bytes;
  logic  out_trunc;

  assign out_free       = !out_valid || ack_out.ready;
  assign s1_move        = s1_valid && (!s1_item.last_chunk || out_free);
  assign chunk_in.ready = !s1_valid || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chunk_in.ready) begin
      s1_valid <= chunk_in.valid;
    end
    if (chunk_in.ready && chunk_in.valid) begin
      s1_item.chunk_index     <= chunk_in.chunk_index;
      s1_item.first_chunk     <= chunk_in.first_chunk;
      s1_item.last_chunk      <= chunk_in.last_chunk;
      s1_item.datagram_length <= chunk_in.datagram_length;
      s1_item.declared_length <= chunk_in.declared_length;
    end
  end

  scar_seq_track u_track (
    .clk      (clk),
    .rst      (rst),
    .advance  (s1_move),
    .item     (s1_item),
    .run_next (run_next)
  );

  // result for the last chunk of a datagram
  always_comb begin
    payload_len = $signed({17'b0, s1_item.datagram_length}) - (DECL_W+1)'(HEADER_BYTES);
    res_trunc   = payload_len <= $signed({s1_item.declared_length[DECL_W-1],
                                           s1_item.declared_length});
    res_finished = (run_next.counted_sum == '0) && (run_next.all_sum == '0);
    cnt_m1  = $signed({2'b0, run_next.count}) - (IDX_W+1)'(1);
    span    = cnt_m1 * CHUNK_BYTES_S;
    whole_s = cnt_m1 - (IDX_W+1)'(res_trunc);
    res_whole = whole_s[IDX_W] ? '0 : whole_s[CNT_W-1:0];
    if (res_trunc) begin
      res_ack   = step_back(run_next.prev);
      res_bytes = decl_t'(CHUNK_BYTES);
    end else begin
      res_ack   = run_next.prev;
      res_bytes = s1_item.declared_length - DECL_W'(span);
    end
    if (res_finished) begin
      res_ack   = idx_t'(-1);
      res_whole = '0;
      res_bytes = '0;
      res_trunc = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_item.last_chunk) begin
      out_valid <= 1'b1;
    end else if (ack_out.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move && s1_item.last_chunk) begin
      out_finished <= res_finished;
      out_ack      <= res_ack;
      out_whole    <= res_whole;
      out_bytes    <= res_bytes;
      out_trunc    <= res_trunc;
    end
  end

  assign ack_out.valid             = out_valid;
  assign ack_out.finished          = out_finished;
  assign ack_out.ack_index         = out_ack;
  assign ack_out.whole_chunks      = out_whole;
  assign ack_out.final_chunk_bytes = out_bytes;
  assign ack_out.truncated         = out_trunc;

  // a last chunk leaving the input stage always lands in the output register
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_item.last_chunk |=> out_valid)
    else $error("last chunk left input stage without a result");

  // input side only backs up when the input stage holds a blocked last chunk
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !chunk_in.ready |-> s1_valid && s1_item.last_chunk && out_valid && !ack_out.ready)
    else $error("input stalled without a blocked result");

  // a blocked input stage keeps its header
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_item))
    else $error("input stage lost a stalled header");

  // once a chunk has been processed the run count is never zero
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> u_track.run.count != '0)
    else $error("run count zero after a processed chunk");

endmodule

`default_nettype wire
